### hdl/c_subset_token_scanner_unit_defines.svh
// Assertion macros shared by the scanner checker.
// No dependencies.
`ifndef C_SUBSET_TOKEN_SCANNER_UNIT_DEFINES_SVH
`define C_SUBSET_TOKEN_SCANNER_UNIT_DEFINES_SVH
// implication checked every clock, quiet during reset
`define CST_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cst check failed");
// next-cycle implication
`define CST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cst check failed");
`endif

### hdl/cst_pkg.sv
// Package for the token scanner: types, codes and decode functions.
// No dependencies.
`timescale 1ns / 1ps
package cst_pkg;
  typedef enum logic [3:0] {
    M_START, M_EQ, M_LT, M_GT, M_BANG, M_SLASH, M_COMMENT, M_CSTAR,
    M_STRING, M_IDENT, M_INT, M_FLOAT, M_DONE
  } scan_mode_t;

  localparam logic [4:0] T_EOF = 5'd0, T_ERR = 5'd1, T_ID = 5'd2, T_KW = 5'd3,
    T_INT = 5'd4, T_FLT = 5'd5, T_STR = 5'd6, T_REL = 5'd7, T_ADD = 5'd8,
    T_MUL = 5'd9, T_ASG = 5'd10, T_SEMI = 5'd11, T_COMMA = 5'd12,
    T_LBRACE = 5'd13, T_RBRACE = 5'd14, T_LPAREN = 5'd15, T_RPAREN = 5'd16;

  localparam logic [3:0] S_EQ = 4'd0, S_NE = 4'd1, S_LT = 4'd2, S_LE = 4'd3,
    S_GT = 4'd4, S_GE = 4'd5, S_PLUS = 4'd0, S_MINUS = 4'd1, S_TIMES = 4'd0,
    S_DIV = 4'd1, S_MOD = 4'd2;

  localparam logic [7:0] RESET_MAX_STR = 8'd80;

  // classified input, front to back
  typedef struct packed {
    logic       eof;
    logic [7:0] ch;
    logic       is_alpha;
    logic       is_digit;
    logic       is_word;
  } cls_item_t;

  // keyword lookup: window of 8 bytes, length; returns hit and index
  function automatic logic [4:0] kw_lookup(input logic [63:0] w, input logic [7:0] n);
    logic [4:0] r;
    r = 5'd0;
    unique case (n)
      8'd2: if (w[15:0] == "fi") r = {1'b1, 4'd2};
      8'd3: if (w[23:0] == "tni") r = {1'b1, 4'd0};
      8'd4: begin
        if (w[31:0] == "esle") r = {1'b1, 4'd3};
        else if (w[31:0] == "diov") r = {1'b1, 4'd8};
      end
      8'd5: begin
        if (w[39:0] == "taolf") r = {1'b1, 4'd1};
        else if (w[39:0] == "elihw") r = {1'b1, 4'd4};
        else if (w[39:0] == "kaerb") r = {1'b1, 4'd5};
      end
      8'd6: if (w[47:0] == "nruter") r = {1'b1, 4'd7};
      8'd8: if (w == "eunitnoc") r = {1'b1, 4'd6};
      default: r = 5'd0;
    endcase
    return r;
  endfunction
endpackage

### hdl/c_subset_token_scanner_unit.sv
// Usage: one source byte per request on in_*, tokens and text bytes on out_*.
// in_end_of_input marks the end of the source; char_code is then ignored.
// One byte gives zero, one or two results (a pushed-back character is
// rescanned in the same cycle). A byte is taken every cycle when the
// receiver keeps up; from input to first result a byte passes the
// classifier queue, then the scan step into the four-slot result queue.
// The scan step waits while fewer than two result slots are free, so a
// stalled receiver fills the queues and then raises in_stall.
// cfg_wr_en writes max_string_length from cfg_wr_data; write only when idle.
// Reset (rst_n low, synchronous): start mode, line 1, queues empty,
// limit 80. Depends on cst_pkg, cst_front and cst_back.
`timescale 1ns / 1ps
module c_subset_token_scanner_unit #(
  parameter int LINE_BITS  = 24,
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_char_code,
  input  logic                  in_end_of_input,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_result_kind,
  output logic [4:0]            out_token_type,
  output logic [3:0]            out_sub_code,
  output logic [LINE_BITS-1:0]  out_line_of_token,
  output logic [VALUE_BITS-1:0] out_number_value,
  output logic [7:0]            out_fraction_digits,
  output logic [7:0]            out_text_length,
  output logic [7:0]            out_text_byte,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data
);
  import cst_pkg::*;
  logic       q_valid, q_pop;
  cls_item_t  q_item;
  logic [7:0] max_len_r;

  // string length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) max_len_r <= RESET_MAX_STR;
    else if (cfg_wr_en) max_len_r <= cfg_wr_data;
  end

  cst_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_char_code, .in_end_of_input,
    .q_valid, .q_item, .q_pop
  );

  cst_back #(.LINE_BITS(LINE_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop, .max_len(max_len_r),
    .out_valid, .out_stall, .out_result_kind, .out_token_type, .out_sub_code,
    .out_line_of_token, .out_number_value, .out_fraction_digits,
    .out_text_length, .out_text_byte
  );
endmodule

### hdl/cst_front.sv
// Front end: accepts source bytes and classifies them into a small queue.
// Depends on cst_pkg.
`timescale 1ns / 1ps
module cst_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_char_code,
  input  logic              in_end_of_input,
  output logic              q_valid,
  output cst_pkg::cls_item_t q_item,
  input  logic              q_pop
);
  import cst_pkg::*;
  // two-entry queue
  cls_item_t mem_r [2];
  cls_item_t mem_nxt0, mem_nxt1, cls;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  always_comb begin
    cls.eof = in_end_of_input;
    cls.ch = in_char_code;
    cls.is_alpha = (in_char_code >= "a" && in_char_code <= "z") ||
                   (in_char_code >= "A" && in_char_code <= "Z");
    cls.is_digit = in_char_code >= "0" && in_char_code <= "9";
    cls.is_word = cls.is_alpha || cls.is_digit || in_char_code == "_";
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = mem_r[0];

  always_comb begin
    mem_nxt0 = mem_r[0];
    mem_nxt1 = mem_r[1];
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
    if (q_pop) mem_nxt0 = mem_r[1];
    if (push) begin
      if (cnt_nxt == 2'd1) mem_nxt0 = cls;
      else mem_nxt1 = cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 2'd0;
    else cnt_r <= cnt_nxt;
    mem_r[0] <= mem_nxt0;
    mem_r[1] <= mem_nxt1;
  end
endmodule

### hdl/cst_back.sv
// Back end: scan state machine, up to two results per item, output queue.
// Depends on cst_pkg.
`timescale 1ns / 1ps
module cst_back #(
  parameter int LINE_BITS  = 24,
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  cst_pkg::cls_item_t    q_item,
  output logic                  q_pop,
  input  logic [7:0]            max_len,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_result_kind,
  output logic [4:0]            out_token_type,
  output logic [3:0]            out_sub_code,
  output logic [LINE_BITS-1:0]  out_line_of_token,
  output logic [VALUE_BITS-1:0] out_number_value,
  output logic [7:0]            out_fraction_digits,
  output logic [7:0]            out_text_length,
  output logic [7:0]            out_text_byte
);
  import cst_pkg::*;
  localparam logic [LINE_BITS-1:0]  LMAX = {LINE_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]  LONE = {{(LINE_BITS-1){1'b0}}, 1'b1};
  localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

  typedef struct packed {
    logic                  kind;
    logic [4:0]            typ;
    logic [3:0]            sub;
    logic [LINE_BITS-1:0]  line;
    logic [VALUE_BITS-1:0] val;
    logic [7:0]            frac;
    logic [7:0]            len;
    logic [7:0]            byt;
  } res_t;

  scan_mode_t mode_r, mode_nxt;
  logic [LINE_BITS-1:0]  line_r, line_nxt, sline_r, sline_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [7:0] len_r, len_nxt, frac_r, frac_nxt;
  logic [63:0] kw_r, kw_nxt;

  // output queue: four result slots
  res_t oq_r [4];
  logic [1:0] rd_r, wr_r;
  logic [2:0] ocnt_r;
  res_t r0, r1;
  logic [1:0] nres;
  logic       step, opop;

  // digit accumulate with saturation: val*10+d, compared against max
  function automatic logic [VALUE_BITS-1:0] add_dig(input logic [VALUE_BITS-1:0] v,
                                                   input logic [7:0] c);
    logic [VALUE_BITS+4:0] t;
    t = {2'b00, v, 3'b000} + {4'b0000, v, 1'b0} + {{(VALUE_BITS+1){1'b0}}, c[3:0]};
    if (t > {5'd0, VMAX}) return VMAX;
    return t[VALUE_BITS-1:0];
  endfunction

  function automatic res_t mk(input logic [4:0] ty, input logic [3:0] sb,
                              input logic [LINE_BITS-1:0] ln, input logic [7:0] ln8,
                              input logic [7:0] b);
    res_t r;
    r = '0;
    r.typ = ty; r.sub = sb; r.line = ln; r.len = ln8; r.byt = b;
    return r;
  endfunction

  // one pass of the scanner on the current state; rescan runs start logic
  always_comb begin
    logic [7:0] c;
    logic e, again, w, inc;
    logic [4:0] kw;
    c = q_item.ch; e = q_item.eof; again = 1'b0;
    w = q_item.is_word;
    kw = kw_lookup(kw_r, len_r);
    mode_nxt = mode_r; line_nxt = line_r; sline_nxt = sline_r; val_nxt = val_r;
    len_nxt = len_r; frac_nxt = frac_r; kw_nxt = kw_r;
    r0 = '0; r1 = '0; nres = 2'd0; inc = 1'b0;
    unique case (mode_r)
      M_EQ, M_LT, M_GT, M_BANG: begin
        mode_nxt = M_START; nres = 2'd1;
        if (!e && c == "=") begin
          unique case (mode_r)
            M_EQ: r0 = mk(T_REL, S_EQ, line_r, 8'd0, 8'd0);
            M_LT: r0 = mk(T_REL, S_LE, line_r, 8'd0, 8'd0);
            M_GT: r0 = mk(T_REL, S_GE, line_r, 8'd0, 8'd0);
            default: r0 = mk(T_REL, S_NE, line_r, 8'd0, 8'd0);
          endcase
        end else begin
          again = 1'b1;
          unique case (mode_r)
            M_EQ: r0 = mk(T_ASG, 4'd0, line_r, 8'd0, 8'd0);
            M_LT: r0 = mk(T_REL, S_LT, line_r, 8'd0, 8'd0);
            M_GT: r0 = mk(T_REL, S_GT, line_r, 8'd0, 8'd0);
            default: r0 = mk(T_ERR, 4'd0, line_r, 8'd1, "!");
          endcase
        end
      end
      M_SLASH: begin
        if (!e && c == "*") mode_nxt = M_COMMENT;
        else begin
          mode_nxt = M_START; again = 1'b1; nres = 2'd1;
          r0 = mk(T_MUL, S_DIV, line_r, 8'd0, 8'd0);
        end
      end
      M_COMMENT, M_CSTAR: begin
        if (e) begin
          mode_nxt = M_DONE; nres = 2'd1; r0 = mk(T_EOF, 4'd0, line_r, 8'd0, 8'd0);
        end else if (c == "*") mode_nxt = M_CSTAR;
        else if (c == "/" && mode_r == M_CSTAR) mode_nxt = M_START;
        else begin
          mode_nxt = M_COMMENT; inc = (c == 8'h0a);
        end
      end
      M_STRING: begin
        if (e) begin
          mode_nxt = M_DONE; nres = 2'd1; r0 = mk(T_EOF, 4'd0, line_r, 8'd0, 8'd0);
        end else if (c == "\"") begin
          mode_nxt = M_START; nres = 2'd1; r0 = mk(T_STR, 4'd0, line_r, len_r, 8'd0);
        end else if (len_r >= max_len) begin
          mode_nxt = M_START; again = 1'b1; nres = 2'd1;
          r0 = mk(T_ERR, 4'd0, line_r, len_r, 8'd0);
        end else begin
          inc = (c == 8'h0a);
          len_nxt = (len_r == 8'hff) ? len_r : len_r + 8'd1;
          nres = 2'd1; r0 = mk(T_STR, 4'd0, sline_r, len_nxt, c); r0.kind = 1'b1;
        end
      end
      M_IDENT: begin
        nres = 2'd1;
        if (!e && w) begin
          if (len_r < 8'd8) kw_nxt[len_r[2:0]*8 +: 8] = c;
          len_nxt = (len_r == 8'hff) ? len_r : len_r + 8'd1;
          r0 = mk(T_ID, 4'd0, sline_r, len_nxt, c); r0.kind = 1'b1;
        end else begin
          again = 1'b1; mode_nxt = M_START;
          r0 = kw[4] ? mk(T_KW, kw[3:0], sline_r, len_r, 8'd0)
                     : mk(T_ID, 4'd0, sline_r, len_r, 8'd0);
        end
      end
      M_INT, M_FLOAT: begin
        nres = 2'd1;
        if (!e && q_item.is_digit) begin
          val_nxt = add_dig(val_r, c);
          if (mode_r == M_FLOAT && frac_r != 8'hff) frac_nxt = frac_r + 8'd1;
          len_nxt = (len_r == 8'hff) ? len_r : len_r + 8'd1;
          r0 = mk((mode_r == M_INT) ? T_INT : T_FLT, 4'd0, sline_r, len_nxt, c);
          r0.kind = 1'b1;
        end else if (!e && c == "." && mode_r == M_INT) begin
          mode_nxt = M_FLOAT; frac_nxt = 8'd0;
          len_nxt = (len_r == 8'hff) ? len_r : len_r + 8'd1;
          r0 = mk(T_FLT, 4'd0, sline_r, len_nxt, c); r0.kind = 1'b1;
        end else begin
          again = 1'b1; mode_nxt = M_START;
          r0 = mk((mode_r == M_INT) ? T_INT : T_FLT, 4'd0, sline_r, len_r, 8'd0);
          r0.val = val_r;
          if (mode_r == M_FLOAT) r0.frac = frac_r;
        end
      end
      M_DONE: begin
        nres = 2'd1; r0 = mk(T_EOF, 4'd0, line_r, 8'd0, 8'd0);
      end
      default: again = 1'b1;
    endcase
    // start-mode scan, first pass or rescan
    if (mode_r == M_START || again) begin
      res_t rs;
      logic has;
      logic [LINE_BITS-1:0] ln;
      rs = '0; has = 1'b1;
      ln = line_r;
      mode_nxt = M_START;
      if (e) begin
        rs = mk(T_EOF, 4'd0, ln, 8'd0, 8'd0); mode_nxt = M_DONE;
      end else begin
        case (c)
          "=": begin has = 1'b0; mode_nxt = M_EQ; end
          "<": begin has = 1'b0; mode_nxt = M_LT; end
          ">": begin has = 1'b0; mode_nxt = M_GT; end
          "!": begin has = 1'b0; mode_nxt = M_BANG; end
          "/": begin has = 1'b0; mode_nxt = M_SLASH; end
          "*": rs = mk(T_MUL, S_TIMES, ln, 8'd0, 8'd0);
          "%": rs = mk(T_MUL, S_MOD, ln, 8'd0, 8'd0);
          "+": rs = mk(T_ADD, S_PLUS, ln, 8'd0, 8'd0);
          "-": rs = mk(T_ADD, S_MINUS, ln, 8'd0, 8'd0);
          ";": rs = mk(T_SEMI, 4'd0, ln, 8'd0, 8'd0);
          ",": rs = mk(T_COMMA, 4'd0, ln, 8'd0, 8'd0);
          "{": rs = mk(T_LBRACE, 4'd0, ln, 8'd0, 8'd0);
          "}": rs = mk(T_RBRACE, 4'd0, ln, 8'd0, 8'd0);
          "(": rs = mk(T_LPAREN, 4'd0, ln, 8'd0, 8'd0);
          ")": rs = mk(T_RPAREN, 4'd0, ln, 8'd0, 8'd0);
          "\"": begin
            has = 1'b0; mode_nxt = M_STRING; len_nxt = 8'd0; sline_nxt = ln;
          end
          " ", 8'h09: has = 1'b0;
          8'h0a: begin has = 1'b0; inc = 1'b1; end
          default: begin
            if (q_item.is_alpha || c == "_") begin
              mode_nxt = M_IDENT; len_nxt = 8'd1; val_nxt = '0; frac_nxt = 8'd0;
              sline_nxt = ln; kw_nxt[7:0] = c;
              rs = mk(T_ID, 4'd0, ln, 8'd1, c); rs.kind = 1'b1;
            end else if (q_item.is_digit) begin
              mode_nxt = M_INT; len_nxt = 8'd1; frac_nxt = 8'd0; sline_nxt = ln;
              val_nxt = add_dig('0, c);
              rs = mk(T_INT, 4'd0, ln, 8'd1, c); rs.kind = 1'b1;
            end else rs = mk(T_ERR, 4'd0, ln, 8'd1, c);
          end
        endcase
      end
      // second slot only when the first pass already gave a result
      if (has) begin
        if (nres != 2'd0) begin r1 = rs; nres = 2'd2; end
        else begin r0 = rs; nres = 2'd1; end
      end
    end
    if (inc && line_r != LMAX) line_nxt = line_r + LONE;
  end

  // take an item only when at least two result slots are free
  assign opop = out_valid && !out_stall;
  assign step = q_valid && (ocnt_r <= 3'd2);
  assign q_pop = step;
  assign out_valid = (ocnt_r != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_START; line_r <= LONE;
      sline_r <= LONE;
      val_r <= '0; len_r <= 8'd0; frac_r <= 8'd0;
      rd_r <= 2'd0; wr_r <= 2'd0; ocnt_r <= 3'd0;
    end else begin
      if (step) begin
        mode_r <= mode_nxt; line_r <= line_nxt; sline_r <= sline_nxt;
        val_r <= val_nxt; len_r <= len_nxt; frac_r <= frac_nxt;
        wr_r <= wr_r + nres;
      end
      if (opop) rd_r <= rd_r + 2'd1;
      ocnt_r <= ocnt_r + (step ? {1'b0, nres} : 3'd0) - {2'b0, opop};
    end
  end

  // result slots and keyword window are payload
  always_ff @(posedge clk) begin
    if (step) begin
      kw_r <= kw_nxt;
      if (nres != 2'd0) oq_r[wr_r] <= r0;
      if (nres == 2'd2) oq_r[wr_r + 2'd1] <= r1;
    end
  end

  assign out_result_kind     = oq_r[rd_r].kind;
  assign out_token_type      = oq_r[rd_r].typ;
  assign out_sub_code        = oq_r[rd_r].sub;
  assign out_line_of_token   = oq_r[rd_r].line;
  assign out_number_value    = oq_r[rd_r].val;
  assign out_fraction_digits = oq_r[rd_r].frac;
  assign out_text_length     = oq_r[rd_r].len;
  assign out_text_byte       = oq_r[rd_r].byt;
endmodule

### hdl/cst_checker.sv
// Port-level checker for the token scanner, bound to the top level.
// Depends on cst_pkg and c_subset_token_scanner_unit_defines.svh.
`timescale 1ns / 1ps
module cst_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_result_kind,
  input logic [4:0] out_token_type,
  input logic [3:0] out_sub_code,
  input logic [7:0] out_text_length
);
  import cst_pkg::*;
  `include "c_subset_token_scanner_unit_defines.svh"
  // stalled result holds
  `CST_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_token_type))
  // text bytes carry a nonzero length
  `CST_ASSERT_IMPL(a_txt_len, out_valid && out_result_kind, out_text_length != 8'd0)
  // token type stays in range
  `CST_ASSERT_IMPL(a_type, out_valid, out_token_type <= T_RPAREN)
  // sub code only on relop, addop, mulop and keywords
  `CST_ASSERT_IMPL(a_sub, out_valid && out_sub_code != 4'd0,
    out_token_type == T_REL || out_token_type == T_ADD ||
    out_token_type == T_MUL || out_token_type == T_KW)
endmodule

bind c_subset_token_scanner_unit cst_checker u_cst_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_result_kind, .out_token_type,
  .out_sub_code, .out_text_length
);

### bench/tb.sv
// Self-checking bench for c_subset_token_scanner_unit: a byte-stream driver,
// a token predictor and an in-order result checker. Depends on cst_pkg.
`timescale 1ns / 1ps
module tb;
  import cst_pkg::*;

  typedef struct {
    bit         eof;
    logic [7:0] ch;
  } src_byte_t;

  typedef struct {
    logic        kind;
    logic [4:0]  ttype;
    logic [3:0]  sub;
    logic [23:0] line;
    logic [30:0] val;
    logic [7:0]  frac;
    logic [7:0]  len;
    logic [7:0]  tbyte;
  } token_t;

  localparam longint LINE_SAT  = 64'hFF_FFFF;
  localparam longint VALUE_SAT = 64'h7FFF_FFFF;
  localparam int     DOG_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid, in_stall, in_end_of_input;
  logic [7:0]  in_char_code;
  logic        out_valid, out_stall, out_result_kind;
  logic [4:0]  out_token_type;
  logic [3:0]  out_sub_code;
  logic [23:0] out_line_of_token;
  logic [30:0] out_number_value;
  logic [7:0]  out_fraction_digits, out_text_length, out_text_byte;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  c_subset_token_scanner_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_char_code(in_char_code),
    .in_end_of_input(in_end_of_input),
    .out_valid(out_valid), .out_stall(out_stall), .out_result_kind(out_result_kind),
    .out_token_type(out_token_type), .out_sub_code(out_sub_code),
    .out_line_of_token(out_line_of_token), .out_number_value(out_number_value),
    .out_fraction_digits(out_fraction_digits), .out_text_length(out_text_length),
    .out_text_byte(out_text_byte),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  src_byte_t   byte_q[$];
  token_t      token_q[$];
  int          err_cnt = 0;
  bit          quiet = 1'b0;

  // scanner shadow state
  scan_mode_t  mode = M_START;
  longint      line_no = 1;
  logic [7:0]  kw_win[8];
  int          tok_len = 0;
  longint      num_val = 0;
  int          frac_cnt = 0;
  longint      tok_line = 1;
  int          str_limit = 80;
  string       kw_names[9] = '{"int", "float", "if", "else", "while", "break",
                               "continue", "return", "void"};

  function automatic bit is_letter(int c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(int c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic push_tok(logic kind, logic [4:0] t, logic [3:0] s, longint ln,
                          longint v, int f, int n, int b);
    token_t r;
    r.kind = kind; r.ttype = t; r.sub = s; r.line = ln[23:0]; r.val = v[30:0];
    r.frac = f[7:0]; r.len = n[7:0]; r.tbyte = b[7:0];
    token_q.push_back(r);
  endtask

  task automatic plain_tok(logic [4:0] t, logic [3:0] s);
    push_tok(1'b0, t, s, line_no, 0, 0, 0, 0);
  endtask

  task automatic text_tok(logic [4:0] t, int c);
    push_tok(1'b1, t, 4'd0, tok_line, 0, 0, tok_len, c);
  endtask

  task automatic bump_line();
    if (line_no < LINE_SAT) line_no++;
  endtask

  task automatic bump_len();
    if (tok_len < 255) tok_len++;
  endtask

  task automatic add_digit(int c);
    longint d;
    d = c - "0";
    if (num_val > (VALUE_SAT - d) / 10) num_val = VALUE_SAT;
    else num_val = num_val * 10 + d;
  endtask

  function automatic int keyword_hit();
    bit ok;
    if (tok_len < 1 || tok_len > 8) return -1;
    for (int k = 0; k < 9; k++) begin
      ok = (kw_names[k].len() == tok_len);
      for (int i = 0; ok && i < tok_len; i++)
        if (kw_names[k][i] != kw_win[i]) ok = 1'b0;
      if (ok) return k;
    end
    return -1;
  endfunction

  task automatic begin_text(scan_mode_t m);
    mode = m; tok_len = 1; num_val = 0; frac_cnt = 0; tok_line = line_no;
  endtask

  // one scan pass; again=1 means the byte is rescanned from start mode
  task automatic scan_pass(int c, bit eof, output bit again);
    int k;
    again = 1'b0;
    case (mode)
      M_START: begin
        if (eof) begin
          plain_tok(T_EOF, 4'd0); mode = M_DONE;
        end else if (c == "=") mode = M_EQ;
        else if (c == "<") mode = M_LT;
        else if (c == ">") mode = M_GT;
        else if (c == "!") mode = M_BANG;
        else if (c == "/") mode = M_SLASH;
        else if (c == "*") plain_tok(T_MUL, S_TIMES);
        else if (c == "%") plain_tok(T_MUL, S_MOD);
        else if (c == "+") plain_tok(T_ADD, S_PLUS);
        else if (c == "-") plain_tok(T_ADD, S_MINUS);
        else if (c == ";") plain_tok(T_SEMI, 4'd0);
        else if (c == ",") plain_tok(T_COMMA, 4'd0);
        else if (c == "{") plain_tok(T_LBRACE, 4'd0);
        else if (c == "}") plain_tok(T_RBRACE, 4'd0);
        else if (c == "(") plain_tok(T_LPAREN, 4'd0);
        else if (c == ")") plain_tok(T_RPAREN, 4'd0);
        else if (c == "\"") begin
          mode = M_STRING; tok_len = 0; tok_line = line_no;
        end else if (c == " " || c == 9) begin
        end else if (c == 10) bump_line();
        else if (is_letter(c) || c == "_") begin
          begin_text(M_IDENT); kw_win[0] = c[7:0]; text_tok(T_ID, c);
        end else if (is_num(c)) begin
          begin_text(M_INT); add_digit(c); text_tok(T_INT, c);
        end else push_tok(1'b0, T_ERR, 4'd0, line_no, 0, 0, 1, c);
      end
      M_EQ, M_LT, M_GT, M_BANG: begin
        if (!eof && c == "=") begin
          case (mode)
            M_EQ: plain_tok(T_REL, S_EQ);
            M_LT: plain_tok(T_REL, S_LE);
            M_GT: plain_tok(T_REL, S_GE);
            default: plain_tok(T_REL, S_NE);
          endcase
        end else begin
          case (mode)
            M_EQ: plain_tok(T_ASG, 4'd0);
            M_LT: plain_tok(T_REL, S_LT);
            M_GT: plain_tok(T_REL, S_GT);
            default: push_tok(1'b0, T_ERR, 4'd0, line_no, 0, 0, 1, "!");
          endcase
          again = 1'b1;
        end
        mode = M_START;
      end
      M_SLASH: begin
        if (!eof && c == "*") mode = M_COMMENT;
        else begin
          mode = M_START; plain_tok(T_MUL, S_DIV); again = 1'b1;
        end
      end
      M_COMMENT, M_CSTAR: begin
        if (eof) begin
          plain_tok(T_EOF, 4'd0); mode = M_DONE;
        end else if (c == "*") mode = M_CSTAR;
        else if (c == "/" && mode == M_CSTAR) mode = M_START;
        else begin
          if (c == 10) bump_line();
          mode = M_COMMENT;
        end
      end
      M_STRING: begin
        if (eof) begin
          plain_tok(T_EOF, 4'd0); mode = M_DONE;
        end else if (c == "\"") begin
          push_tok(1'b0, T_STR, 4'd0, line_no, 0, 0, tok_len, 0); mode = M_START;
        end else if (tok_len >= str_limit) begin
          push_tok(1'b0, T_ERR, 4'd0, line_no, 0, 0, tok_len, 0);
          mode = M_START; again = 1'b1;
        end else begin
          if (c == 10) bump_line();
          bump_len(); text_tok(T_STR, c);
        end
      end
      M_IDENT: begin
        if (!eof && (is_letter(c) || is_num(c) || c == "_")) begin
          if (tok_len < 8) kw_win[tok_len] = c[7:0];
          bump_len(); text_tok(T_ID, c);
        end else begin
          k = keyword_hit();
          if (k >= 0) push_tok(1'b0, T_KW, k[3:0], tok_line, 0, 0, tok_len, 0);
          else push_tok(1'b0, T_ID, 4'd0, tok_line, 0, 0, tok_len, 0);
          mode = M_START; again = 1'b1;
        end
      end
      M_INT: begin
        if (!eof && is_num(c)) begin
          add_digit(c); bump_len(); text_tok(T_INT, c);
        end else if (!eof && c == ".") begin
          mode = M_FLOAT; frac_cnt = 0; bump_len(); text_tok(T_FLT, c);
        end else begin
          push_tok(1'b0, T_INT, 4'd0, tok_line, num_val, 0, tok_len, 0);
          mode = M_START; again = 1'b1;
        end
      end
      M_FLOAT: begin
        if (!eof && is_num(c)) begin
          add_digit(c);
          if (frac_cnt < 255) frac_cnt++;
          bump_len(); text_tok(T_FLT, c);
        end else begin
          push_tok(1'b0, T_FLT, 4'd0, tok_line, num_val, frac_cnt, tok_len, 0);
          mode = M_START; again = 1'b1;
        end
      end
      M_DONE: plain_tok(T_EOF, 4'd0);
      default: begin
        mode = M_START; again = 1'b1;
      end
    endcase
  endtask

  task automatic predict_tokens(int c, bit eof);
    bit again;
    scan_pass(c, eof, again);
    if (again) scan_pass(c, eof, again);
  endtask

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // request acceptance on both sides: predict, then compare in order
  int     dog = 0;
  token_t want;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_tokens(in_char_code, in_end_of_input);
      if (out_valid && !out_stall) begin
        if (token_q.size() == 0) begin
          $error("result_kind: expected none, got %0d", out_result_kind);
          err_cnt++;
        end else begin
          want = token_q.pop_front();
          check_field("result_kind", want.kind, out_result_kind);
          check_field("token_type", want.ttype, out_token_type);
          check_field("sub_code", want.sub, out_sub_code);
          check_field("line_of_token", want.line, out_line_of_token);
          check_field("number_value", want.val, out_number_value);
          check_field("fraction_digits", want.frac, out_fraction_digits);
          check_field("text_length", want.len, out_text_length);
          check_field("text_byte", want.tbyte, out_text_byte);
        end
      end
      // watchdog on cycles with no request moving
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) dog <= 0;
      else dog <= dog + 1;
      if (dog >= DOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // byte driver with random gaps
  int        in_gap = 0;
  src_byte_t drv_item;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        drv_item = byte_q.pop_front();
        in_valid <= 1'b1;
        in_char_code <= drv_item.ch;
        in_end_of_input <= drv_item.eof;
        if (!quiet && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall bursts
  int out_gap = 0;
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_gap <= $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic put(int c);
    src_byte_t s;
    s.eof = 1'b0; s.ch = c[7:0];
    byte_q.push_back(s);
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  function automatic int word_char();
    case ($urandom_range(0, 3))
      0: return $urandom_range("a", "z");
      1: return $urandom_range("A", "Z");
      2: return $urandom_range("0", "9");
      default: return "_";
    endcase
  endfunction

  // one random source fragment, mostly well-formed
  task automatic put_fragment();
    int n;
    int c;
    string ops[19] = '{"==", "!=", "<=", ">=", "<", ">", "=", "!", "/", "*", "%",
                       "+", "-", ";", ",", "{", "}", "(", ")"};
    case ($urandom_range(0, 11))
      0, 1: begin
        if ($urandom_range(0, 2) == 0) put_str(kw_names[$urandom_range(0, 8)]);
        else begin
          put($urandom_range(0, 1) ? $urandom_range("a", "z") : "_");
          n = $urandom_range(0, 9);
          repeat (n) put(word_char());
        end
      end
      2: begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
        repeat (n) put($urandom_range("0", "9"));
      end
      3: begin
        repeat ($urandom_range(1, 4)) put($urandom_range("0", "9"));
        put(".");
        repeat ($urandom_range(0, 5)) put($urandom_range("0", "9"));
      end
      4: begin
        put("\"");
        n = ($urandom_range(0, 3) == 0) ? str_limit - 1 + $urandom_range(0, 3)
                                        : $urandom_range(0, 12);
        repeat (n) begin
          c = $urandom_range(0, 255);
          put(c == "\"" ? "x" : c);
        end
        put("\"");
      end
      5: begin
        put_str("/*");
        repeat ($urandom_range(0, 8)) begin
          c = $urandom_range(0, 3) == 0 ? "*" : $urandom_range(0, 255);
          put(c == "/" ? 10 : c);
        end
        put_str($urandom_range(0, 1) ? "*/" : "**/");
      end
      6, 7, 8: put_str(ops[$urandom_range(0, 18)]);
      9: put($urandom_range(0, 1) ? 10 : ($urandom_range(0, 1) ? " " : 9));
      10: put($urandom_range(0, 255));
      default: put(" ");
    endcase
  endtask

  task automatic put_random(int count);
    int stop_at;
    stop_at = byte_q.size() + count;
    while (byte_q.size() < stop_at) put_fragment();
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (byte_q.size() != 0 || in_valid || token_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_limit(int v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[7:0];
    str_limit = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    src_byte_t e;
    foreach (kw_win[i]) kw_win[i] = 8'd0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_code = 8'd0;
    in_end_of_input = 1'b0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: relations, lone bang, float, empty comment ended by stars, odd bytes
    put_str("while x1>=3.25!y/**/");
    put(8'hFF); put(13); put_str("%<=!= 99999999999;");
    put_random(220);
    wait_idle();

    // tightest string limit
    write_limit(1);
    put_str("\"\" \"a\" \"ab\n\"");
    put_random(250);
    wait_idle();

    // widest limit, long identifier past the text length cap
    write_limit(255);
    put("A");
    repeat (259) put(word_char());
    put(" ");
    put_random(250);
    wait_idle();

    write_limit($urandom_range(2, 254));
    put_random(250);
    wait_idle();

    // last part with no idling; open comment at end of input, then more ends
    write_limit(80);
    quiet = 1'b1;
    put_random(250);
    put_str(" /* open *");
    repeat (4) begin
      e.eof = 1'b1;
      e.ch = $urandom_range(0, 255);
      byte_q.push_back(e);
    end
    wait_idle();

    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

### files.f
+incdir+hdl
hdl/cst_pkg.sv
hdl/cst_front.sv
hdl/cst_back.sv
hdl/c_subset_token_scanner_unit.sv
hdl/cst_checker.sv
bench/tb.sv
